// ----- hw/rtl/stsp_pkg.sv -----
// shared types and constants for the string-table stream parser
package stsp_pkg;

  localparam logic [2:0] KIND_NAME   = 3'd0;
  localparam logic [2:0] KIND_VALUE  = 3'd1;
  localparam logic [2:0] KIND_EXTRA  = 3'd2;
  localparam logic [2:0] KIND_ENTRY  = 3'd3;
  localparam logic [2:0] KIND_HEADER = 3'd4;
  localparam logic [2:0] KIND_OK     = 3'd5;
  localparam logic [2:0] KIND_ERROR  = 3'd6;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_NOT_CSF   = 4'd1;
  localparam logic [3:0] ERR_VERSION   = 4'd2;
  localparam logic [3:0] ERR_LBL_MAGIC = 4'd3;
  localparam logic [3:0] ERR_NAME_LEN  = 4'd4;
  localparam logic [3:0] ERR_NAME_RNG  = 4'd5;
  localparam logic [3:0] ERR_VAL_HDR   = 4'd6;
  localparam logic [3:0] ERR_VAL_MAGIC = 4'd7;
  localparam logic [3:0] ERR_VAL_RNG   = 4'd8;
  localparam logic [3:0] ERR_XTR_LEN   = 4'd9;
  localparam logic [3:0] ERR_XTR_RNG   = 4'd10;
  localparam logic [3:0] ERR_TRAILING  = 4'd11;

  localparam logic [1:0] REG_VERSION = 2'd0;
  localparam logic [1:0] REG_NAME    = 2'd1;
  localparam logic [1:0] REG_VALUE   = 2'd2;
  localparam logic [1:0] REG_EXTRA   = 2'd3;

  localparam logic [31:0] MAGIC_RTS  = 32'h5354_5220;
  localparam logic [31:0] MAGIC_WRTS = 32'h5354_5257;
  localparam logic [31:0] MAGIC_HDR  = 32'h4353_4620;
  localparam logic [31:0] MAGIC_LBL  = 32'h4C42_4C20;

  localparam int MAX_RESULTS = 5;

  typedef enum logic [3:0] {
    PH_HDR, PH_LBL, PH_NLEN, PH_NAME, PH_VHDR, PH_VAL, PH_XLEN, PH_XTR, PH_END
  } phase_t;

  // one result item
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_value;
    logic [31:0] entry_number;
    logic        value_present;
    logic [31:0] language;
    logic [31:0] entry_count;
    logic [3:0]  error_code;
  } result_t;

  // configuration register set
  typedef struct packed {
    logic [31:0] expected_version;
    logic [15:0] name_limit;
    logic [16:0] value_limit;
    logic [15:0] extra_limit;
  } cfg_t;

  // results of one input byte, in order
  typedef struct packed {
    logic [2:0] count;
    result_t [MAX_RESULTS-1:0] res;
  } batch_t;

endpackage

// ----- hw/rtl/stsp_cfg.sv -----
// configuration register file
module stsp_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output stsp_pkg::cfg_t    cfg
);
  import stsp_pkg::*;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_version <= 32'd3;
      cfg.name_limit <= 16'd4096;
      cfg.value_limit <= 17'd65536;
      cfg.extra_limit <= 16'd4096;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_VERSION: cfg.expected_version <= cfg_data;
        REG_NAME:    cfg.name_limit <= cfg_data[15:0];
        REG_VALUE:   cfg.value_limit <= cfg_data[16:0];
        REG_EXTRA:   cfg.extra_limit <= cfg_data[15:0];
        default: ;
      endcase
    end
  end
endmodule

// ----- hw/rtl/stsp_parse.sv -----
// parse state and per-byte result generation
module stsp_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       byte_in,
  input  logic             final_byte,
  input  stsp_pkg::cfg_t   cfg,
  output stsp_pkg::batch_t batch
);
  import stsp_pkg::*;

  phase_t      phase, phase_next;
  logic [4:0]  field_counter, field_counter_next;
  logic [32:0] field_length, field_length_next;
  logic [31:0] word_shift, word_shift_next;
  logic [31:0] entries_left, entries_left_next;
  logic [31:0] entry_index, entry_index_next;
  logic        value_flag, value_flag_next;
  logic        wide_value_kind, wide_value_kind_next;
  logic [7:0]  low_unit_byte, low_unit_byte_next;
  logic        version_bad, version_bad_next;
  logic        halted, halted_next;
  logic [31:0] shifted;
  logic [15:0] unit;
  logic [31:0] idx;

  assign shifted = {byte_in, word_shift[31:8]};
  assign unit = ~{byte_in, low_unit_byte};

  always_comb begin
    result_t r;
    logic [2:0] n;
    logic done_entry;
    logic fail;
    logic [3:0] fcode;
    logic [7:0] mb;
    r = '0;
    n = 3'd0;
    done_entry = 1'b0;
    fail = 1'b0;
    fcode = ERR_NONE;
    mb = 8'd0;
    batch = '0;
    phase_next = phase;
    field_counter_next = field_counter;
    field_length_next = field_length;
    word_shift_next = word_shift;
    entries_left_next = entries_left;
    entry_index_next = entry_index;
    value_flag_next = value_flag;
    wide_value_kind_next = wide_value_kind;
    low_unit_byte_next = low_unit_byte;
    version_bad_next = version_bad;
    halted_next = halted;
    idx = entry_index;
    if (!halted) begin
      unique case (phase)
        PH_HDR: begin
          word_shift_next = shifted;
          mb = MAGIC_HDR[8*field_counter[1:0] +: 8];
          if (field_counter < 5'd4 && byte_in != mb) begin
            fail = 1'b1; fcode = ERR_NOT_CSF;
          end else begin
            if (field_counter == 5'd7) version_bad_next = shifted != cfg.expected_version;
            if (field_counter == 5'd11) entries_left_next = shifted;
            field_counter_next = field_counter + 5'd1;
            if (field_counter == 5'd23) begin
              if (version_bad) begin
                fail = 1'b1; fcode = ERR_VERSION;
              end else begin
                r = '0; r.kind = KIND_HEADER; r.entry_number = idx;
                r.language = shifted; r.entry_count = entries_left;
                batch.res[n] = r; n = n + 3'd1;
                phase_next = (entries_left != 0) ? PH_LBL : PH_END;
                field_counter_next = '0;
              end
            end
          end
        end
        PH_LBL: begin
          word_shift_next = shifted;
          mb = MAGIC_LBL[8*field_counter[1:0] +: 8];
          if (field_counter < 5'd4 && byte_in != mb) begin
            fail = 1'b1; fcode = ERR_LBL_MAGIC;
          end else begin
            if (field_counter == 5'd7) value_flag_next = shifted[0];
            field_counter_next = field_counter + 5'd1;
            if (field_counter == 5'd7) begin
              phase_next = PH_NLEN; field_counter_next = '0;
            end
          end
        end
        PH_NLEN: begin
          word_shift_next = shifted;
          field_counter_next = field_counter + 5'd1;
          if (field_counter == 5'd3) begin
            if (shifted > {16'd0, cfg.name_limit}) begin
              fail = 1'b1; fcode = ERR_NAME_RNG;
            end else begin
              field_length_next = {1'b0, shifted};
              phase_next = PH_NAME; field_counter_next = '0;
              if (shifted == 0) begin
                if (value_flag) phase_next = PH_VHDR;
                else done_entry = 1'b1;
              end
            end
          end
        end
        PH_NAME: begin
          r = '0; r.kind = KIND_NAME; r.entry_number = idx;
          r.byte_value = (byte_in >= 8'h41 && byte_in <= 8'h5A) ? byte_in + 8'h20 : byte_in;
          batch.res[n] = r; n = n + 3'd1;
          field_length_next = field_length - 33'd1;
          if (field_length == 33'd1) begin
            if (value_flag) begin
              phase_next = PH_VHDR; field_counter_next = '0;
            end else done_entry = 1'b1;
          end
        end
        PH_VHDR: begin
          word_shift_next = shifted;
          field_counter_next = field_counter + 5'd1;
          if (field_counter == 5'd3) field_length_next = {1'b0, shifted};
          if (field_counter == 5'd7) begin
            if (field_length[31:0] != MAGIC_RTS && field_length[31:0] != MAGIC_WRTS) begin
              fail = 1'b1; fcode = ERR_VAL_MAGIC;
            end else begin
              wide_value_kind_next = field_length[31:0] == MAGIC_WRTS;
              if (shifted > {15'd0, cfg.value_limit}) begin
                fail = 1'b1; fcode = ERR_VAL_RNG;
              end else begin
                field_length_next = {shifted, 1'b0};
                phase_next = PH_VAL; field_counter_next = '0;
                if (shifted == 0) begin
                  if (field_length[31:0] == MAGIC_WRTS) phase_next = PH_XLEN;
                  else done_entry = 1'b1;
                end
              end
            end
          end
        end
        PH_VAL: begin
          if (!field_length[0]) low_unit_byte_next = byte_in;
          else begin
            r = '0; r.kind = KIND_VALUE; r.entry_number = idx;
            if (unit < 16'h0080) begin
              r.byte_value = unit[7:0]; batch.res[n] = r; n = n + 3'd1;
            end else if (unit < 16'h0800) begin
              r.byte_value = 8'hC0 | {3'd0, unit[10:6]}; batch.res[n] = r; n = n + 3'd1;
              r.byte_value = 8'h80 | {2'd0, unit[5:0]}; batch.res[n] = r; n = n + 3'd1;
            end else begin
              r.byte_value = 8'hE0 | {4'd0, unit[15:12]}; batch.res[n] = r; n = n + 3'd1;
              r.byte_value = 8'h80 | {2'd0, unit[11:6]}; batch.res[n] = r; n = n + 3'd1;
              r.byte_value = 8'h80 | {2'd0, unit[5:0]}; batch.res[n] = r; n = n + 3'd1;
            end
          end
          field_length_next = field_length - 33'd1;
          if (field_length == 33'd1) begin
            if (wide_value_kind) begin
              phase_next = PH_XLEN; field_counter_next = '0;
            end else done_entry = 1'b1;
          end
        end
        PH_XLEN: begin
          word_shift_next = shifted;
          field_counter_next = field_counter + 5'd1;
          if (field_counter == 5'd3) begin
            if (shifted > {16'd0, cfg.extra_limit}) begin
              fail = 1'b1; fcode = ERR_XTR_RNG;
            end else begin
              field_length_next = {1'b0, shifted};
              phase_next = PH_XTR; field_counter_next = '0;
              if (shifted == 0) done_entry = 1'b1;
            end
          end
        end
        PH_XTR: begin
          r = '0; r.kind = KIND_EXTRA; r.entry_number = idx; r.byte_value = byte_in;
          batch.res[n] = r; n = n + 3'd1;
          field_length_next = field_length - 33'd1;
          if (field_length == 33'd1) done_entry = 1'b1;
        end
        default: begin
          fail = 1'b1; fcode = ERR_TRAILING;
        end
      endcase
      // entry completion
      if (done_entry) begin
        r = '0; r.kind = KIND_ENTRY; r.entry_number = idx; r.value_present = value_flag_next;
        batch.res[n] = r; n = n + 3'd1;
        idx = entry_index + 32'd1;
        entry_index_next = idx;
        entries_left_next = entries_left - 32'd1;
        phase_next = (entries_left != 32'd1) ? PH_LBL : PH_END;
        field_counter_next = '0;
      end
      // truncation or end of file
      if (!fail && final_byte) begin
        if (phase_next == PH_END) begin
          r = '0; r.kind = KIND_OK; r.entry_number = idx;
          batch.res[n] = r; n = n + 3'd1;
        end else begin
          fail = 1'b1;
          case (phase_next)
            PH_HDR:  fcode = ERR_NOT_CSF;
            PH_LBL:  fcode = ERR_LBL_MAGIC;
            PH_NLEN: fcode = ERR_NAME_LEN;
            PH_NAME: fcode = ERR_NAME_RNG;
            PH_VHDR: fcode = ERR_VAL_HDR;
            PH_VAL:  fcode = ERR_VAL_RNG;
            PH_XLEN: fcode = ERR_XTR_LEN;
            PH_XTR:  fcode = ERR_XTR_RNG;
            default: fcode = ERR_NOT_CSF;
          endcase
        end
      end
      if (fail) begin
        r = '0; r.kind = KIND_ERROR; r.entry_number = idx; r.error_code = fcode;
        batch.res[n] = r; n = n + 3'd1;
        halted_next = 1'b1;
      end
    end
    batch.count = n;
    if (final_byte) begin
      phase_next = PH_HDR; field_counter_next = '0; field_length_next = '0;
      word_shift_next = '0; entries_left_next = '0; entry_index_next = '0;
      value_flag_next = 1'b0; wide_value_kind_next = 1'b0;
      low_unit_byte_next = '0; version_bad_next = 1'b0; halted_next = 1'b0;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR; field_counter <= '0; field_length <= '0;
      word_shift <= '0; entries_left <= '0; entry_index <= '0;
      value_flag <= 1'b0; wide_value_kind <= 1'b0; low_unit_byte <= '0;
      version_bad <= 1'b0; halted <= 1'b0;
    end else if (step) begin
      phase <= phase_next; field_counter <= field_counter_next;
      field_length <= field_length_next; word_shift <= word_shift_next;
      entries_left <= entries_left_next; entry_index <= entry_index_next;
      value_flag <= value_flag_next; wide_value_kind <= wide_value_kind_next;
      low_unit_byte <= low_unit_byte_next; version_bad <= version_bad_next;
      halted <= halted_next;
    end
  end
endmodule

// ----- hw/rtl/stsp_out.sv -----
// result register that hands out a batch one item a cycle unless stalled
module stsp_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  stsp_pkg::batch_t batch,
  input  logic             stall,
  output logic             busy,
  output logic             valid,
  output stsp_pkg::result_t res,
  output logic             last
);
  import stsp_pkg::*;

  result_t [MAX_RESULTS-1:0] held;
  logic [2:0] count;
  logic [2:0] pos;
  logic       pop;

  assign valid = count != 3'd0;
  assign pop = valid && !stall;
  assign last = valid && (pos == count - 3'd1);
  assign busy = valid && !(pop && last);
  assign res = held[pos];

  // batch register and read position
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pos <= '0;
    end else if (load) begin
      count <= batch.count;
      pos <= '0;
    end else if (pop) begin
      if (last) count <= '0;
      pos <= last ? 3'd0 : pos + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) held <= batch.res;
  end

  assert property (@(posedge clk) disable iff (rst) valid |-> pos < count)
    else $error("read position past batch");
  assert property (@(posedge clk) disable iff (rst) load |-> !busy)
    else $error("batch loaded over pending results");
  assert property (@(posedge clk) disable iff (rst) (valid && stall) |=> valid && $stable(pos))
    else $error("stalled result moved");
endmodule

// ----- hw/rtl/string_table_stream_parser.sv -----
// top level of the string-table stream parser
// Use: bytes of a string-table file enter on the input channel (in_valid,
// in_stall, byte_in, final_byte), final_byte high on the last byte. Results
// leave on the output channel (out_valid, out_stall and the result fields),
// one item per cycle while out_stall is low; last_of_run marks the last
// result of an input byte. Each byte is decoded combinationally into up to
// five results, held in a result register and handed out one per cycle
// unless stalled. The first result appears in the cycle after the byte is
// accepted. A byte that causes results occupies the output until its last
// result is taken, so the next byte is taken in the cycle its predecessor's
// last result is taken; bytes without results flow at one per cycle. A
// UTF-16 unit (two bytes) gives up to three results, so in value text the
// result register, not the decode, sets the pace.
// Reset clears parse state and sets registers to their defaults; after the
// final byte the parse state returns to its reset value for the next file.
// Configuration: cfg_write with cfg_index and cfg_data, written while idle.
module string_table_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_in,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  byte_value,
  output logic [31:0] entry_number,
  output logic        value_present,
  output logic [31:0] language,
  output logic [31:0] entry_count,
  output logic [3:0]  error_code,
  output logic        last_of_run,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import stsp_pkg::*;

  cfg_t    cfg;
  batch_t  batch;
  result_t res;
  logic    busy;
  logic    step;

  assign in_stall = busy;
  assign step = in_valid && !busy;

  stsp_cfg u_cfg (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  stsp_parse u_parse (
    .clk(clk), .rst(rst), .step(step), .byte_in(byte_in),
    .final_byte(final_byte), .cfg(cfg), .batch(batch)
  );

  stsp_out u_out (
    .clk(clk), .rst(rst), .load(step), .batch(batch), .stall(out_stall),
    .busy(busy), .valid(out_valid), .res(res), .last(last_of_run)
  );

  assign kind = res.kind;
  assign byte_value = res.byte_value;
  assign entry_number = res.entry_number;
  assign value_present = res.value_present;
  assign language = res.language;
  assign entry_count = res.entry_count;
  assign error_code = res.error_code;
endmodule
